// File: rtl/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg: shared types and constants for the triangular quantile pipeline
// Fixed-point constants, side-band structs and the Q60 product slice.
// ----------------------------------------------------------------------------
package tq_pkg;

  localparam int EXP_TERMS   = 20;
  localparam int EXP_SQUARES = 5;
  localparam int SQRT_BITS   = 44;
  localparam int RAD_W       = 2 * SQRT_BITS;

  localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
  localparam logic [32:0] EXP_LIMIT = 33'h0_1200_0000;

  // Side band that rides along the exponential pipeline.
  typedef struct packed {
    logic [31:0] x;
    logic        zero;
  } exp_side_t;

  // Side band that rides along the product and square root pipeline.
  typedef struct packed {
    logic low;
    logic rng_err;
  } tail_side_t;

  // Truncated Q60 value of a full product of two Q60 operands.
  function automatic logic [63:0] q60_trunc(input logic [127:0] p);
    return p[123:60];
  endfunction

endpackage

// File: rtl/triangular_quantile.sv
// ----------------------------------------------------------------------------
// triangular_quantile: streaming inverse CDF of the triangular distribution
// Probability in signed Q8.24, quantile out in signed Q16.16 with a status.
// ----------------------------------------------------------------------------
// Usage: write min, max, mode, tail and log flags on the cfg_ port (indexes
// 0 to 4, one write per cycle, no wait) while no transaction is in flight.
// Each transaction on the in_ channel carries one probability and produces
// exactly one transaction on the out_ channel, in order.
// The path is a pipeline: 132 stages of exponential (Taylor terms,
// squarings), three stages of tail selection, scaling and branch logic,
// a two-stage product and a 44-stage square root, one bit per stage, then
// the output register.
// Throughput is one transaction per cycle while out_ready stays high.
// When the receiver stalls, the output register holds its result and a skid
// register catches the one following result; in_ready falls only once the
// skid register is full, and the whole pipeline then freezes in place.
// Reset (synchronous, active low) empties the pipeline and restores the
// default distribution on [0, 1] with mode 0.5, lower tail, linear input.
// ----------------------------------------------------------------------------
module triangular_quantile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_prob_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_quantile,
  output logic [1:0]  out_status
);
  import tq_pkg::*;

  localparam logic [2:0]  CFG_MIN   = 3'd0;
  localparam logic [2:0]  CFG_MAX   = 3'd1;
  localparam logic [2:0]  CFG_MODE  = 3'd2;
  localparam logic [2:0]  CFG_LOWER = 3'd3;
  localparam logic [2:0]  CFG_LOG   = 3'd4;
  localparam logic [1:0]  ST_OK     = 2'd0;
  localparam logic [1:0]  ST_PARAM  = 2'd1;
  localparam logic [1:0]  ST_RANGE  = 2'd2;
  localparam logic [33:0] ONE_Q24   = 34'h100_0000;
  localparam int          TSW       = $bits(tail_side_t);

  // Configuration registers.
  logic [31:0] min_value_r, max_value_r, mode_value_r;
  logic        lower_tail_r, log_input_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r  <= 32'd0;
      max_value_r  <= 32'd65536;
      mode_value_r <= 32'd32768;
      lower_tail_r <= 1'b1;
      log_input_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN:   min_value_r  <= cfg_wdata;
        CFG_MAX:   max_value_r  <= cfg_wdata;
        CFG_MODE:  mode_value_r <= cfg_wdata;
        CFG_LOWER: lower_tail_r <= cfg_wdata[0];
        CFG_LOG:   log_input_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The user must keep configuration static while transactions are in flight;
  // the block does not enforce it. Stages read these derived values directly.
  logic [31:0] len_w, a_w, b_w;
  logic        param_bad;

  assign len_w     = max_value_r - min_value_r;
  assign a_w       = mode_value_r - min_value_r;
  assign b_w       = max_value_r - mode_value_r;
  assign param_bad = ($signed(min_value_r) >= $signed(max_value_r))
                  || ($signed(mode_value_r) > $signed(max_value_r))
                  || ($signed(min_value_r) > $signed(mode_value_r));

  logic en;
  logic skid_vld_r;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  // Exponential of the log input; linear inputs simply ride along.
  logic        ex_vld;
  logic [31:0] ex_x;
  logic [27:0] ex_u;

  tq_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_x   (in_prob_in),
    .out_vld(ex_vld),
    .out_x  (ex_x),
    .out_u  (ex_u)
  );

  // Stage U1: tail selection and range check.
  logic signed [33:0] u_raw, u_tail;
  logic               u1_vld_r, u1_err_r;
  logic [24:0]        u1_u_r;

  always_comb begin
    if (log_input_r) begin
      u_raw = ($signed(ex_x) > 32'sd0) ? $signed(ONE_Q24 + 34'd1) : $signed({6'b0, ex_u});
    end else begin
      u_raw = $signed({{2{ex_x[31]}}, ex_x});
    end
    u_tail = lower_tail_r ? u_raw : $signed(ONE_Q24) - u_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_u_r   <= u_tail[24:0];
      u1_err_r <= u_tail[33] || (u_tail > $signed(ONE_Q24));
    end
  end

  // Stage U2: u * L.
  logic        u2_err_r;
  logic [56:0] u2_ul_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u2_ul_r  <= 57'(u1_u_r) * 57'(len_w);
      u2_err_r <= u1_err_r;
    end
  end

  // Stage U3: branch choice, exact against A in Q24.
  logic        low_w;
  logic [56:0] len_q;
  logic        u3_vld_r;
  logic [56:0] u3_m1_r;
  logic [31:0] u3_m2_r;
  tail_side_t  u3_side_r;
  logic        u2_vld_r;

  assign low_w = u2_ul_r < {1'b0, a_w, 24'b0};
  assign len_q = {1'b0, len_w, 24'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      u3_m1_r           <= low_w ? u2_ul_r : (len_q - u2_ul_r);
      u3_m2_r           <= low_w ? a_w : b_w;
      u3_side_r.low     <= low_w;
      u3_side_r.rng_err <= u2_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_vld_r <= 1'b0;
      u2_vld_r <= 1'b0;
      u3_vld_r <= 1'b0;
    end else if (en) begin
      u1_vld_r <= ex_vld;
      u2_vld_r <= u1_vld_r;
      u3_vld_r <= u2_vld_r;
    end
  end

  // Radicand and square root.
  logic           pm_vld;
  logic [127:0]   pm_p;
  logic [TSW-1:0] pm_side;

  tq_mul64 #(.SW(TSW)) u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (u3_vld_r),
    .in_a    ({7'b0, u3_m1_r}),
    .in_b    ({32'b0, u3_m2_r}),
    .in_side (u3_side_r),
    .out_vld (pm_vld),
    .out_p   (pm_p),
    .out_side(pm_side)
  );

  logic                 sq_vld;
  logic [SQRT_BITS-1:0] sq_root;
  logic [TSW-1:0]       sq_side;
  tail_side_t           fin_side;

  tq_sqrt #(.SW(TSW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pm_vld),
    .in_rad  (pm_p[RAD_W-1:0]),
    .in_side (pm_side),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_side(sq_side)
  );

  // Final result: round the root to Q16.16 and apply it from min or max.
  logic [44:0] off_sum;
  logic [31:0] off_w, q_w, res_q;
  logic [1:0]  res_st;

  assign fin_side = tail_side_t'(sq_side);
  assign off_sum  = {1'b0, sq_root} + 45'd2048;
  assign off_w    = off_sum[43:12];
  assign q_w      = fin_side.low ? (min_value_r + off_w) : (max_value_r - off_w);

  always_comb begin
    priority if (param_bad) begin
      res_st = ST_PARAM;
    end else if (fin_side.rng_err) begin
      res_st = ST_RANGE;
    end else begin
      res_st = ST_OK;
    end
    res_q = (res_st == ST_OK) ? q_w : 32'd0;
  end

  // Output register plus one skid entry.
  logic        out_vld_r;
  logic [31:0] out_q_r, skid_q_r;
  logic [1:0]  out_st_r, skid_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (sq_vld) begin
      if (out_vld_r && !out_ready) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ready) begin
        out_q_r  <= skid_q_r;
        out_st_r <= skid_st_r;
      end
    end else if (sq_vld) begin
      if (out_vld_r && !out_ready) begin
        skid_q_r  <= res_q;
        skid_st_r <= res_st;
      end else begin
        out_q_r  <= res_q;
        out_st_r <= res_st;
      end
    end
  end

  assign out_valid    = out_vld_r;
  assign out_quantile = out_q_r;
  assign out_status   = out_st_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without a result in the output register");

  a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_ready |=> skid_vld_r)
    else $error("skid entry dropped while the receiver stalls");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_st_r != ST_OK |-> out_q_r == 32'd0)
    else $error("nonzero quantile with an error status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_st_r == ST_OK || out_st_r == ST_PARAM || out_st_r == ST_RANGE))
    else $error("undefined status code on the output");
`endif

endmodule

// File: rtl/tq_mul64.sv
// ----------------------------------------------------------------------------
// tq_mul64: two-stage 64x64 unsigned multiplier
// Four 32x32 partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
module tq_mul64 #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [63:0]   in_a,
  input  logic [63:0]   in_b,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [127:0]  out_p,
  output logic [SW-1:0] out_side
);

  logic [63:0]   p00_r, p01_r, p10_r, p11_r;
  logic [SW-1:0] side_r, oside_r;
  logic          vld_r, ovld_r;
  logic [127:0]  p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= in_vld;
      ovld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r   <= 64'(in_a[31:0])  * 64'(in_b[31:0]);
      p01_r   <= 64'(in_a[31:0])  * 64'(in_b[63:32]);
      p10_r   <= 64'(in_a[63:32]) * 64'(in_b[31:0]);
      p11_r   <= 64'(in_a[63:32]) * 64'(in_b[63:32]);
      side_r  <= in_side;
      p_r     <= {p11_r, 64'b0} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
                 + {64'b0, p00_r};
      oside_r <= side_r;
    end
  end

  assign out_vld  = ovld_r;
  assign out_p    = p_r;
  assign out_side = oside_r;

endmodule

// File: rtl/tq_exp_term.sv
// ----------------------------------------------------------------------------
// tq_exp_term: one Taylor term of exp(-r)
// Multiplies the previous term by r, divides by N and updates the sum.
// ----------------------------------------------------------------------------
module tq_exp_term #(
  parameter int N = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [63:0]       in_term,
  input  logic [63:0]       in_sum,
  input  logic [63:0]       in_r,
  input  tq_pkg::exp_side_t in_side,
  output logic              out_vld,
  output logic [63:0]       out_term,
  output logic [63:0]       out_sum,
  output logic [63:0]       out_r,
  output tq_pkg::exp_side_t out_side
);
  import tq_pkg::*;

  localparam int          ESW   = $bits(exp_side_t);
  localparam int          SW    = 128 + ESW;
  localparam int          RSH   = 16;
  localparam logic [16:0] RECIP = 17'((1 << RSH) / N + 1);
  localparam bit          ODD   = (N % 2) == 1;
  localparam int          DST   = 4;

  // One byte of long division by N; the remainder stays below N.
  // Returns the new remainder above the quotient byte.
  function automatic logic [12:0] div_step(input logic [4:0] rem_in, input logic [7:0] din);
    logic [12:0] cur;
    logic [29:0] est;
    logic [8:0]  qd;
    logic [13:0] qn;
    cur = {rem_in, din};
    est = 30'(cur) * 30'(RECIP);
    qd  = est[RSH +: 9];
    qn  = 14'(qd) * 14'(N);
    if (qn > {1'b0, cur}) begin
      qd = qd - 9'd1;
      qn = qn - 14'(N);
    end
    return {5'(cur - qn[12:0]), qd[7:0]};
  endfunction

  logic           m_vld;
  logic [127:0]   m_p;
  logic [SW-1:0]  m_side;
  logic           dv_s [0:DST-1];
  logic [63:0]    dn_s [0:DST-1];
  logic [63:0]    dq_s [0:DST-1];
  logic [4:0]     dr_s [0:DST-1];
  logic [SW-1:0]  ds_s [0:DST-1];
  logic [12:0]    f_hi, f_lo;
  logic [63:0]    m_sum, t_new;
  logic           vld_r;
  logic [63:0]    term_r, sum_r, r_r;
  exp_side_t      side_r;

  tq_mul64 #(.SW(SW)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_vld),
    .in_a    (in_term),
    .in_b    (in_r),
    .in_side ({in_sum, in_r, in_side}),
    .out_vld (m_vld),
    .out_p   (m_p),
    .out_side(m_side)
  );

  assign dv_s[0] = m_vld;
  assign dn_s[0] = q60_trunc(m_p);
  assign dq_s[0] = '0;
  assign dr_s[0] = '0;
  assign ds_s[0] = m_side;

  // The division by N runs two bytes per stage, most significant first.
  for (genvar k = 0; k < DST - 1; k++) begin : g_div
    logic [12:0]   s_hi, s_lo;
    logic          dvld_r;
    logic [63:0]   dn_r, dq_r;
    logic [4:0]    drem_r;
    logic [SW-1:0] dside_r;

    assign s_hi = div_step(dr_s[k], dn_s[k][63 - 16 * k -: 8]);
    assign s_lo = div_step(s_hi[12:8], dn_s[k][55 - 16 * k -: 8]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r <= 1'b0;
      end else if (en) begin
        dvld_r <= dv_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn_r    <= dn_s[k];
        dq_r    <= dq_s[k] | (64'({s_hi[7:0], s_lo[7:0]}) << (48 - 16 * k));
        drem_r  <= s_lo[12:8];
        dside_r <= ds_s[k];
      end
    end

    assign dv_s[k+1] = dvld_r;
    assign dn_s[k+1] = dn_r;
    assign dq_s[k+1] = dq_r;
    assign dr_s[k+1] = drem_r;
    assign ds_s[k+1] = dside_r;
  end

  assign f_hi  = div_step(dr_s[DST-1], dn_s[DST-1][15:8]);
  assign f_lo  = div_step(f_hi[12:8], dn_s[DST-1][7:0]);
  assign t_new = {dq_s[DST-1][63:16], f_hi[7:0], f_lo[7:0]};
  assign m_sum = ds_s[DST-1][SW-1 -: 64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= dv_s[DST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= t_new;
      sum_r  <= ODD ? (m_sum - t_new) : (m_sum + t_new);
      r_r    <= ds_s[DST-1][SW-65 -: 64];
      side_r <= exp_side_t'(ds_s[DST-1][ESW-1:0]);
    end
  end

  assign out_vld  = vld_r;
  assign out_term = term_r;
  assign out_sum  = sum_r;
  assign out_r    = r_r;
  assign out_side = side_r;

endmodule

// File: rtl/tq_exp.sv
// ----------------------------------------------------------------------------
// tq_exp: pipelined exp(x) for x <= 0 in Q8.24
// Twenty Taylor terms of exp(x/32), five squarings, rounding to Q24.
// ----------------------------------------------------------------------------
module tq_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] in_x,
  output logic        out_vld,
  output logic [31:0] out_x,
  output logic [27:0] out_u
);
  import tq_pkg::*;

  localparam int ESW = $bits(exp_side_t);

  logic [32:0] neg_y;
  logic        e_vld_r;
  logic [63:0] e_r_r;
  exp_side_t   e_side_r;

  assign neg_y = 33'd0 - {in_x[31], in_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= in_vld;
    end
  end

  // r = y / 32 in Q60; inputs of 18.0 and beyond underflow to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      e_r_r         <= {neg_y, 31'b0};
      e_side_r.x    <= in_x;
      e_side_r.zero <= $signed(neg_y) >= $signed(EXP_LIMIT);
    end
  end

  logic        t_vld  [0:EXP_TERMS];
  logic [63:0] t_term [0:EXP_TERMS];
  logic [63:0] t_sum  [0:EXP_TERMS];
  logic [63:0] t_r    [0:EXP_TERMS];
  exp_side_t   t_side [0:EXP_TERMS];

  assign t_vld[0]  = e_vld_r;
  assign t_term[0] = ONE_Q60;
  assign t_sum[0]  = ONE_Q60;
  assign t_r[0]    = e_r_r;
  assign t_side[0] = e_side_r;

  for (genvar n = 1; n <= EXP_TERMS; n++) begin : g_term
    tq_exp_term #(.N(n)) u_term (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (t_vld[n-1]),
      .in_term (t_term[n-1]),
      .in_sum  (t_sum[n-1]),
      .in_r    (t_r[n-1]),
      .in_side (t_side[n-1]),
      .out_vld (t_vld[n]),
      .out_term(t_term[n]),
      .out_sum (t_sum[n]),
      .out_r   (t_r[n]),
      .out_side(t_side[n])
    );
  end

  logic           s_vld  [0:EXP_SQUARES];
  logic [63:0]    s_val  [0:EXP_SQUARES];
  logic [ESW-1:0] s_side [0:EXP_SQUARES];
  logic [127:0]   s_p    [0:EXP_SQUARES-1];

  assign s_vld[0]  = t_vld[EXP_TERMS];
  assign s_val[0]  = t_sum[EXP_TERMS];
  assign s_side[0] = t_side[EXP_TERMS];

  for (genvar k = 0; k < EXP_SQUARES; k++) begin : g_square
    tq_mul64 #(.SW(ESW)) u_sq (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (s_vld[k]),
      .in_a    (s_val[k]),
      .in_b    (s_val[k]),
      .in_side (s_side[k]),
      .out_vld (s_vld[k+1]),
      .out_p   (s_p[k]),
      .out_side(s_side[k+1])
    );
    assign s_val[k+1] = q60_trunc(s_p[k]);
  end

  logic [63:0] rnd;
  exp_side_t   fin_side;
  logic        o_vld_r;
  logic [31:0] o_x_r;
  logic [27:0] o_u_r;

  assign rnd      = s_val[EXP_SQUARES] + 64'h0000_0008_0000_0000;
  assign fin_side = exp_side_t'(s_side[EXP_SQUARES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= s_vld[EXP_SQUARES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_x_r <= fin_side.x;
      o_u_r <= fin_side.zero ? 28'd0 : rnd[63:36];
    end
  end

  assign out_vld = o_vld_r;
  assign out_x   = o_x_r;
  assign out_u   = o_u_r;

endmodule

// File: rtl/tq_sqrt.sv
// ----------------------------------------------------------------------------
// tq_sqrt: pipelined integer square root
// One result bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module tq_sqrt #(
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [tq_pkg::RAD_W-1:0]     in_rad,
  input  logic [SW-1:0]                in_side,
  output logic                         out_vld,
  output logic [tq_pkg::SQRT_BITS-1:0] out_root,
  output logic [SW-1:0]                out_side
);
  import tq_pkg::*;

  logic             vld_s  [0:SQRT_BITS];
  logic [RAD_W-1:0] x_s    [0:SQRT_BITS];
  logic [RAD_W-1:0] res_s  [0:SQRT_BITS];
  logic [SW-1:0]    side_s [0:SQRT_BITS];

  assign vld_s[0]  = in_vld;
  assign x_s[0]    = in_rad;
  assign res_s[0]  = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_BITS - 1 - k));

    logic [RAD_W-1:0] trial;
    logic             vld_r;
    logic [RAD_W-1:0] x_r, res_r;
    logic [SW-1:0]    side_r;

    assign trial = res_s[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r <= side_s[k];
        if (x_s[k] >= trial) begin
          x_r   <= x_s[k] - trial;
          res_r <= (res_s[k] >> 1) + BIT;
        end else begin
          x_r   <= x_s[k];
          res_r <= res_s[k] >> 1;
        end
      end
    end

    assign vld_s[k+1]  = vld_r;
    assign x_s[k+1]    = x_r;
    assign res_s[k+1]  = res_r;
    assign side_s[k+1] = side_r;
  end

  assign out_vld  = vld_s[SQRT_BITS];
  assign out_root = res_s[SQRT_BITS][SQRT_BITS-1:0];
  assign out_side = side_s[SQRT_BITS];

endmodule

// File: tb/triangular_quantile_tb.sv
// ----------------------------------------------------------------------------
// triangular_quantile_tb: self-checking bench for the triangular quantile block
// A directed table covers reset defaults, probability and log edges, both
// tails, extreme and invalid parameters, and a write to an unused index.
// Random phases then reconfigure the distribution and stream probabilities
// under random input gaps and output stalls. Each result is compared with
// its table value, or else with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module triangular_quantile_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_MIN    = 3'd0;
  localparam logic [2:0] REG_MAX    = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_TAIL   = 3'd3;
  localparam logic [2:0] REG_LOG    = 3'd4;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PARAM = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam longint ONE_Q24 = 64'd1 << 24;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] value;
    bit          known;
    logic [31:0] quantile;
    logic [1:0]  status;
  } stim_row_t;

  typedef struct {
    logic [31:0] quantile;
    logic [1:0]  status;
  } quantile_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_prob_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_quantile;
  logic [1:0]  out_status;

  // Shadow copy of the distribution registers.
  logic [31:0] dist_min = 32'd0;
  logic [31:0] dist_max = 32'd65536;
  logic [31:0] dist_mode = 32'd32768;
  logic        dist_lower = 1'b1;
  logic        dist_log = 1'b0;

  quantile_result_t pending_quantiles[$];
  bit               next_known = 0;
  quantile_result_t next_typed;
  int               mismatches = 0;
  bit               no_gaps = 0;
  bit               no_stalls = 0;
  int               stall_hold = 0;

  triangular_quantile u_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series of exp(-y/32) squared five times; y is in Q24 units.
  function automatic longint exp_neg_prob(logic [63:0] y);
    logic [63:0] r, term, sum;
    if (y >= (64'd18 << 24)) return 0;
    r = y << 31;
    term = ONE_Q60;
    sum = ONE_Q60;
    for (int n = 1; n <= 20; n++) begin
      term = q60_product(term, r) / n;
      if (n % 2) sum = sum - term;
      else sum = sum + term;
    end
    for (int n = 0; n < 5; n++) sum = q60_product(sum, sum);
    return longint'((sum + (64'd1 << 35)) >> 36);
  endfunction

  function automatic logic [63:0] root_of_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0]  res, c;
    p = {64'd0, a} * {64'd0, b};
    res = 0;
    for (int bitpos = 43; bitpos >= 0; bitpos--) begin
      c = res | (64'd1 << bitpos);
      if (({64'd0, c} * {64'd0, c}) <= p) res = c;
    end
    return res;
  endfunction

  function automatic quantile_result_t predict_quantile(logic [31:0] prob);
    quantile_result_t res;
    longint lo, hi, md, x, u, q;
    logic [63:0] span, below, above, off;
    lo = longint'($signed(dist_min));
    hi = longint'($signed(dist_max));
    md = longint'($signed(dist_mode));
    x = longint'($signed(prob));
    res.quantile = '0;
    if (lo >= hi || md > hi || lo > md) begin
      res.status = ST_BAD_PARAM;
      return res;
    end
    if (dist_log) u = (x > 0) ? ONE_Q24 + 1 : exp_neg_prob(-x);
    else u = x;
    if (!dist_lower) u = ONE_Q24 - u;
    if (u < 0 || u > ONE_Q24) begin
      res.status = ST_RANGE;
      return res;
    end
    span = hi - lo;
    below = md - lo;
    above = hi - md;
    if (64'(u) * span < (below << 24)) begin
      off = (root_of_product(64'(u) * span, below) + 64'd2048) >> 12;
      q = lo + longint'(off);
    end else begin
      off = (root_of_product(64'(ONE_Q24 - u) * span, above) + 64'd2048) >> 12;
      q = hi - longint'(off);
    end
    res.quantile = q[31:0];
    res.status = ST_OK;
    return res;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The first edge lets the monitor record a transaction accepted just now.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_quantiles.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN:  dist_min = value;
      REG_MAX:  dist_max = value;
      REG_MODE: dist_mode = value;
      REG_TAIL: dist_lower = value[0];
      REG_LOG:  dist_log = value[0];
      default: ;
    endcase
  endtask

  task automatic send_prob(logic [31:0] prob, bit known, logic [31:0] q, logic [1:0] st);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    next_known <= known;
    next_typed.quantile <= q;
    next_typed.status <= st;
    in_valid <= 1'b1;
    in_prob_in <= prob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(logic [31:0] prob);
    send_prob(prob, 0, '0, ST_OK);
  endtask

  function automatic logic [31:0] random_prob();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (dist_log) begin
      if (r < 15) return $urandom_range(1, 32'h7fff_ffff);
      if (r < 20) return -$urandom_range(32'h11ff_ff00, 32'h1200_0100);
      if (r < 50) return -$urandom_range(0, 32'h0400_0000);
      return -$urandom_range(0, 32'h1300_0000);
    end
    if (r < 15) return (r % 2) ? 32'h0100_0000 : 32'h0;
    if (r < 20) return (r % 2) ? -$urandom_range(1, 100) : 32'h0100_0000 + $urandom_range(1, 100);
    return $urandom_range(0, 32'h0100_0000);
  endfunction

  task automatic random_config();
    int kind;
    int v[3];
    int t;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) v[i] = $signed($urandom) >>> $urandom_range(0, 24);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2 - i; j++)
        if (v[j] > v[j+1]) begin
          t = v[j]; v[j] = v[j+1]; v[j+1] = t;
        end
    case (kind)
      6: begin v[0] = 32'h8000_0000; v[2] = 32'h7fff_ffff; end
      7: begin t = v[0]; v[0] = v[2]; v[2] = t; end
      8: v[1] = v[0];
      9: v[1] = v[2];
      default: ;
    endcase
    write_reg(REG_MIN, v[0]);
    write_reg(REG_MAX, v[2]);
    write_reg(REG_MODE, v[1]);
    write_reg(REG_TAIL, $urandom_range(0, 1));
    write_reg(REG_LOG, $urandom_range(0, 1));
  endtask

  stim_row_t directed[] = '{
    '{ROW_ITEM, 3'd0, 32'h0000_0000, 1, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0100_0000, 1, 32'd65536, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0080_0000, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0000_0001, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'hffff_ffff, 1, 32'd0, ST_RANGE},
    '{ROW_ITEM, 3'd0, 32'h0100_0001, 1, 32'd0, ST_RANGE},
    '{ROW_ITEM, 3'd0, 32'h7fff_ffff, 1, 32'd0, ST_RANGE},
    '{ROW_ITEM, 3'd0, 32'h8000_0000, 1, 32'd0, ST_RANGE},
    '{ROW_CFG, REG_TAIL, 32'd0, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0000_0000, 1, 32'd65536, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0100_0000, 1, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0040_0000, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_LOG, 32'd1, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0000_0000, 1, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0000_0001, 1, 32'd0, ST_RANGE},
    '{ROW_ITEM, 3'd0, 32'h7fff_ffff, 1, 32'd0, ST_RANGE},
    '{ROW_ITEM, 3'd0, 32'h8000_0000, 1, 32'd65536, ST_OK},
    '{ROW_ITEM, 3'd0, 32'hee00_0000, 1, 32'd65536, ST_OK},
    '{ROW_ITEM, 3'd0, 32'hee00_0001, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'hff00_0000, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_TAIL, 32'd1, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'hf800_0000, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_MIN, 32'h8000_0000, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_MAX, 32'h7fff_ffff, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_MODE, 32'h8000_0000, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_LOG, 32'd0, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0080_0000, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0100_0000, 1, 32'h7fff_ffff, ST_OK},
    '{ROW_CFG, REG_MODE, 32'h7fff_ffff, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0000_0001, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0000_0000, 1, 32'h8000_0000, ST_OK},
    '{ROW_CFG, REG_MAX, 32'h8000_0000, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0080_0000, 1, 32'd0, ST_BAD_PARAM},
    // An index past the last register must not disturb anything.
    '{ROW_CFG, REG_UNUSED, 32'h0000_0000, 0, 32'd0, ST_OK},
    // Bad parameters win over an out-of-range probability.
    '{ROW_ITEM, 3'd0, 32'hffff_ffff, 1, 32'd0, ST_BAD_PARAM},
    '{ROW_CFG, REG_MIN, 32'd0, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_MAX, 32'd100, 0, 32'd0, ST_OK},
    '{ROW_CFG, REG_MODE, 32'd200, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0080_0000, 1, 32'd0, ST_BAD_PARAM},
    '{ROW_CFG, REG_MODE, 32'hffff_fffb, 0, 32'd0, ST_OK},
    '{ROW_ITEM, 3'd0, 32'h0080_0000, 1, 32'd0, ST_BAD_PARAM}
  };

  // Receiver with random stalls, some long, and stretches of none.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) no_stalls <= !no_stalls;
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_ready <= 1'b0;
      end else if (no_stalls) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_hold <= $urandom_range(10, 60);
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= 30;
      end
    end
  end

  always @(posedge clk) begin
    quantile_result_t exp_res;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (next_known) pending_quantiles.push_back(next_typed);
        else pending_quantiles.push_back(predict_quantile(in_prob_in));
      end
      if (out_valid && out_ready) begin
        if (pending_quantiles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: quantile %h status %0d",
                     out_quantile, out_status);
        end else begin
          exp_res = pending_quantiles.pop_front();
          if (out_quantile !== exp_res.quantile || out_status !== exp_res.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected quantile %h status %0d, got %h status %0d",
                       exp_res.quantile, exp_res.status, out_quantile, out_status);
          end
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("[triangular_quantile] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        send_prob(directed[i].value, directed[i].known, directed[i].quantile,
                  directed[i].status);
      end
    end
    for (int phase = 0; phase < 10; phase++) begin
      in_valid <= 1'b0;
      random_config();
      no_gaps = (phase % 3 == 1);
      for (int n = 0; n < 150; n++) send_random(random_prob());
    end
    in_valid <= 1'b0;
    wait_idle();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending_quantiles.size() == 0) begin
      $display("[triangular_quantile] OK");
    end else begin
      $display("[triangular_quantile] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tq_pkg.sv
rtl/tq_mul64.sv
rtl/tq_exp_term.sv
rtl/tq_exp.sv
rtl/tq_sqrt.sv
rtl/triangular_quantile.sv
tb/triangular_quantile_tb.sv
